### src/c2d_pkg.sv
// ----------------------------------------------------------------------------
// c2d_pkg
// shared types and codes for the convolution block
// ----------------------------------------------------------------------------
package c2d_pkg;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_WEIGHT  = 2'd1,
    KIND_BIAS    = 2'd2,
    KIND_COMPUTE = 2'd3
  } kind_t;

  localparam int unsigned OUT_W = 40;

  // one classified item, passed from front to back
  typedef struct packed {
    kind_t        kind;
    logic [4:0]   filter_index;
    logic [1:0]   channel;
    logic [4:0]   row;
    logic [4:0]   col;
    logic [15:0]  sample_value;
    logic [31:0]  bias_value;
  } cmd_t;

endpackage

### src/c2d_if.sv
// ----------------------------------------------------------------------------
// c2d_in_if / c2d_out_if
// valid/ready channels carrying input items and result items
// ----------------------------------------------------------------------------
interface c2d_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [4:0]         filter_index;
  logic [1:0]         channel;
  logic [4:0]         row;
  logic [4:0]         col;
  logic signed [15:0] sample_value;
  logic signed [31:0] bias_value;
  modport source (output valid, kind, filter_index, channel, row, col,
                  sample_value, bias_value, input ready);
  modport sink   (input valid, kind, filter_index, channel, row, col,
                  sample_value, bias_value, output ready);
endinterface

interface c2d_out_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] out_value;
  modport source (output valid, out_value, input ready);
  modport sink   (input valid, out_value, output ready);
endinterface

### src/conv2d_im2col_mac.sv
// ----------------------------------------------------------------------------
// conv2d_im2col_mac
// stride-1 unpadded convolution with per-filter bias, one output per compute item
// ----------------------------------------------------------------------------
// Load items are written to the stores by the back end; a compute item is run
// by the single multiply-accumulate unit that walks the taps one per cycle
// through the single read port of each store. A four-item queue lets loads be
// taken while a compute runs; out-of-range items are dropped in the front end.
// Stores are not cleared: reading an unwritten entry gives an undefined value.
module conv2d_im2col_mac #(
  parameter int CHANNELS  = 4,
  parameter int IN_HEIGHT = 32,
  parameter int IN_WIDTH  = 32,
  parameter int KERNEL_H  = 5,
  parameter int KERNEL_W  = 5,
  parameter int FILTERS   = 32
) (
  input  logic      clk,
  input  logic      rst,
  c2d_in_if.sink    in_ch,
  c2d_out_if.source out_ch
);

  logic          q_valid;
  logic          q_pop;
  c2d_pkg::cmd_t q_cmd;

  // front end: classify and queue
  c2d_front #(.CHANNELS(CHANNELS), .IN_HEIGHT(IN_HEIGHT), .IN_WIDTH(IN_WIDTH),
              .KERNEL_H(KERNEL_H), .KERNEL_W(KERNEL_W), .FILTERS(FILTERS))
    u_front (.clk(clk), .rst(rst), .in_ch(in_ch), .q_valid(q_valid),
             .q_cmd(q_cmd), .q_pop(q_pop));

  // back end: stores and mac
  c2d_back #(.CHANNELS(CHANNELS), .IN_HEIGHT(IN_HEIGHT), .IN_WIDTH(IN_WIDTH),
             .KERNEL_H(KERNEL_H), .KERNEL_W(KERNEL_W), .FILTERS(FILTERS))
    u_back (.clk(clk), .rst(rst), .q_valid(q_valid), .q_cmd(q_cmd),
            .q_pop(q_pop), .out_ch(out_ch));

endmodule

### src/c2d_front.sv
// ----------------------------------------------------------------------------
// c2d_front
// accepts items, drops those out of range, queues the rest for the back end
// ----------------------------------------------------------------------------
module c2d_front #(
  parameter int CHANNELS  = 4,
  parameter int IN_HEIGHT = 32,
  parameter int IN_WIDTH  = 32,
  parameter int KERNEL_H  = 5,
  parameter int KERNEL_W  = 5,
  parameter int FILTERS   = 32
) (
  input  logic          clk,
  input  logic          rst,
  c2d_in_if.sink        in_ch,
  output logic          q_valid,
  output c2d_pkg::cmd_t q_cmd,
  input  logic          q_pop
);

  localparam int DEPTH = 4;

  c2d_pkg::cmd_t cmd;
  logic          keep;
  c2d_pkg::cmd_t fifo [DEPTH];
  logic [1:0]    wr_ptr;
  logic [1:0]    rd_ptr;
  logic [2:0]    count;
  logic          push;

  // range check per kind
  always_comb begin
    cmd.kind         = c2d_pkg::kind_t'(in_ch.kind);
    cmd.filter_index = in_ch.filter_index;
    cmd.channel      = in_ch.channel;
    cmd.row          = in_ch.row;
    cmd.col          = in_ch.col;
    cmd.sample_value = in_ch.sample_value;
    cmd.bias_value   = in_ch.bias_value;
    unique case (cmd.kind)
      c2d_pkg::KIND_SAMPLE:
        keep = 32'(in_ch.channel) < CHANNELS && 32'(in_ch.row) < IN_HEIGHT
               && 32'(in_ch.col) < IN_WIDTH;
      c2d_pkg::KIND_WEIGHT:
        keep = 32'(in_ch.filter_index) < FILTERS && 32'(in_ch.channel) < CHANNELS
               && 32'(in_ch.row) < KERNEL_H && 32'(in_ch.col) < KERNEL_W;
      c2d_pkg::KIND_BIAS:
        keep = 32'(in_ch.filter_index) < FILTERS;
      default:
        keep = 32'(in_ch.filter_index) < FILTERS
               && 32'(in_ch.row) + KERNEL_H <= IN_HEIGHT
               && 32'(in_ch.col) + KERNEL_W <= IN_WIDTH;
    endcase
  end

  assign in_ch.ready = count < 3'(DEPTH);
  assign push        = in_ch.valid && in_ch.ready && keep;
  assign q_valid     = count != 3'd0;
  assign q_cmd       = fifo[rd_ptr];

  // short item queue
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (q_pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(q_pop);
    end
  end

endmodule

### src/c2d_back.sv
// ----------------------------------------------------------------------------
// c2d_back
// writes the stores and runs the multiply-accumulate loop for compute items
// ----------------------------------------------------------------------------
module c2d_back #(
  parameter int CHANNELS  = 4,
  parameter int IN_HEIGHT = 32,
  parameter int IN_WIDTH  = 32,
  parameter int KERNEL_H  = 5,
  parameter int KERNEL_W  = 5,
  parameter int FILTERS   = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  c2d_pkg::cmd_t q_cmd,
  output logic          q_pop,
  c2d_out_if.source     out_ch
);

  localparam int MAP_D = CHANNELS * IN_HEIGHT * IN_WIDTH;
  localparam int TAPS  = CHANNELS * KERNEL_H * KERNEL_W;
  localparam int W_D   = FILTERS * TAPS;
  localparam int MA_W  = $clog2(MAP_D);
  localparam int WA_W  = $clog2(W_D);
  localparam int FA_W  = FILTERS > 1 ? $clog2(FILTERS) : 1;
  localparam int CW    = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
  localparam int KHW   = KERNEL_H > 1 ? $clog2(KERNEL_H) : 1;
  localparam int KWW   = KERNEL_W > 1 ? $clog2(KERNEL_W) : 1;
  localparam int ACC_W = 64;
  localparam logic signed [ACC_W-1:0] OMAX = (64'sd1 <<< 39) - 64'sd1;
  localparam logic signed [ACC_W-1:0] OMIN = -(64'sd1 <<< 39);

  typedef enum logic [1:0] {IDLE, RUN, DRAIN, DONE} state_t;

  logic signed [15:0] map_mem [MAP_D];
  logic signed [15:0] w_mem   [W_D];
  logic signed [31:0] b_mem   [FILTERS];

  state_t             state;
  logic [CW-1:0]      c;
  logic [KHW-1:0]     r;
  logic [KWW-1:0]     s;
  logic [4:0]         orow, ocol;
  logic [FA_W-1:0]    f;
  logic [FA_W-1:0]    q_f;
  logic [WA_W-1:0]    w_addr;
  logic [MA_W-1:0]    x_addr;
  logic signed [15:0] w_q, x_q;
  logic               rd_vld, prod_vld;
  logic signed [31:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] sat;
  logic               last;

  assign q_f = FA_W'(q_cmd.filter_index);

  // store addresses from the item or the loop counters
  always_comb begin
    logic [31:0] wa, xa;
    wa = 32'(((32'(f) * CHANNELS + 32'(c)) * KERNEL_H + 32'(r)) * KERNEL_W + 32'(s));
    xa = 32'((32'(c) * IN_HEIGHT + 32'(orow) + 32'(r)) * IN_WIDTH + 32'(ocol) + 32'(s));
    if (state == IDLE) begin
      wa = 32'(((32'(q_cmd.filter_index) * CHANNELS + 32'(q_cmd.channel)) * KERNEL_H
           + 32'(q_cmd.row)) * KERNEL_W + 32'(q_cmd.col));
      xa = 32'((32'(q_cmd.channel) * IN_HEIGHT + 32'(q_cmd.row)) * IN_WIDTH
           + 32'(q_cmd.col));
    end
    w_addr = wa[WA_W-1:0];
    x_addr = xa[MA_W-1:0];
  end

  assign last  = 32'(c) == CHANNELS - 1 && 32'(r) == KERNEL_H - 1
                 && 32'(s) == KERNEL_W - 1;
  assign q_pop = state == IDLE && q_valid;
  assign sat   = acc > OMAX ? OMAX : (acc < OMIN ? OMIN : acc);

  // stores: at most one write and one read each per cycle, map and weight read data registered
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.kind == c2d_pkg::KIND_SAMPLE) map_mem[x_addr] <= q_cmd.sample_value;
    if (q_pop && q_cmd.kind == c2d_pkg::KIND_WEIGHT) w_mem[w_addr] <= q_cmd.sample_value;
    if (q_pop && q_cmd.kind == c2d_pkg::KIND_BIAS)
      b_mem[q_f] <= q_cmd.bias_value;
    w_q  <= w_mem[w_addr];
    x_q  <= map_mem[x_addr];
    prod <= w_q * x_q;
  end

  // sequencer, accumulator and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      rd_vld       <= 1'b0;
      prod_vld     <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      prod_vld <= rd_vld;
      if (prod_vld) acc <= acc + ACC_W'(prod);
      unique case (state)
        IDLE: begin
          if (q_pop && q_cmd.kind == c2d_pkg::KIND_COMPUTE) begin
            f     <= q_f;
            orow  <= q_cmd.row;
            ocol  <= q_cmd.col;
            c     <= '0;
            r     <= '0;
            s     <= '0;
            acc   <= ACC_W'(b_mem[q_f]);
            state <= RUN;
          end
        end
        RUN: begin
          rd_vld <= 1'b1;
          if (last) begin
            state <= DRAIN;
          end else if (32'(s) == KERNEL_W - 1) begin
            s <= '0;
            if (32'(r) == KERNEL_H - 1) begin
              r <= '0;
              c <= c + CW'(1);
            end else begin
              r <= r + KHW'(1);
            end
          end else begin
            s <= s + KWW'(1);
          end
        end
        DRAIN: begin
          rd_vld <= 1'b0;
          if (!rd_vld && !prod_vld) state <= DONE;
        end
        default: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid     <= 1'b1;
            out_ch.out_value <= sat[39:0];
            state            <= IDLE;
          end
        end
      endcase
      if (out_ch.valid && out_ch.ready && state != DONE) out_ch.valid <= 1'b0;
    end
  end

endmodule

### src/c2d_checker.sv
// ----------------------------------------------------------------------------
// c2d_checker
// port-level checks on the convolution block
// ----------------------------------------------------------------------------
module c2d_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [39:0] out_value
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result changed while stalled");

  // no result straight after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  // a compute item taken right after reset must not give a result too early
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $past(rst) && in_valid && in_ready && in_kind == c2d_pkg::KIND_COMPUTE
    |=> ##2 !out_valid)
    else $error("result too early");

endmodule

bind conv2d_im2col_mac c2d_checker u_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_kind(in_ch.kind),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_value(out_ch.out_value)
);
